>>> rtl/modexp_pkg.sv
// Shared types, constants and the microcode ROM of the modular exponentiation block.
// No dependencies; used by modexp_useq and modular_exponentiation.
package modexp_pkg;

  localparam int PC_W = 4;

  // Configuration register indexes
  localparam logic CFG_EXPONENT = 1'b0;
  localparam logic CFG_MODULUS  = 1'b1;

  // Branch conditions: jump to target when the condition holds, else fall through
  typedef enum logic [2:0] {
    C_NONE,      // never jump
    C_ALWAYS,    // unconditional jump
    C_NO_IN,     // no input transaction this cycle
    C_SPECIAL,   // exponent or modulus zero: result known up front
    C_BIT_CLR,   // current exponent bit is clear
    C_NOT_LAST,  // more exponent bits to scan
    C_MUL_BUSY,  // modular multiply not finished
    C_OUT_FULL   // result register occupied and not taken
  } cond_t;

  typedef enum logic [1:0] {
    A_ONE,
    A_RES,
    A_SQ
  } asel_t;

  typedef enum logic {
    B_BASE,
    B_SQ
  } bsel_t;

  typedef enum logic [1:0] {
    D_NONE,
    D_SQ,
    D_RES
  } dsel_t;

  typedef struct packed {
    cond_t             cond;
    logic [PC_W-1:0]   target;
    logic              load;      // take input transaction
    logic              start_mul; // launch modular multiply
    asel_t             a_sel;
    bsel_t             b_sel;
    dsel_t             dst;       // destination written when the multiply finishes
    logic              idx_inc;   // advance exponent bit index
    logic              emit;      // write the result register
  } ucode_t;

  // Status flags from the datapath into the sequencer
  typedef struct packed {
    logic in_valid;
    logic special;
    logic exp_bit;
    logic last_bit;
    logic mul_done;
    logic out_block;
  } useq_stat_t;

  localparam logic [PC_W-1:0] PC_IDLE   = 4'd0;
  localparam logic [PC_W-1:0] PC_BITTST = 4'd4;
  localparam logic [PC_W-1:0] PC_SQSTRT = 4'd7;
  localparam logic [PC_W-1:0] PC_EMIT   = 4'd10;

  function automatic ucode_t uc_word(input cond_t c, input logic [PC_W-1:0] t,
                                     input logic ld, input logic st, input asel_t a,
                                     input bsel_t b, input dsel_t d, input logic inc,
                                     input logic em);
    ucode_t w;
    w.cond      = c;
    w.target    = t;
    w.load      = ld;
    w.start_mul = st;
    w.a_sel     = a;
    w.b_sel     = b;
    w.dst       = d;
    w.idx_inc   = inc;
    w.emit      = em;
    return w;
  endfunction

  // Program: reduce base, then per exponent bit an optional multiply and a square.
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    case (pc)
      4'd0:    w = uc_word(C_NO_IN,    4'd0,      1'b1, 1'b0, A_ONE, B_BASE, D_NONE, 1'b0, 1'b0);
      4'd1:    w = uc_word(C_SPECIAL,  PC_EMIT,   1'b0, 1'b0, A_ONE, B_BASE, D_NONE, 1'b0, 1'b0);
      4'd2:    w = uc_word(C_NONE,     4'd0,      1'b0, 1'b1, A_ONE, B_BASE, D_NONE, 1'b0, 1'b0);
      4'd3:    w = uc_word(C_MUL_BUSY, 4'd3,      1'b0, 1'b0, A_ONE, B_BASE, D_SQ,   1'b0, 1'b0);
      4'd4:    w = uc_word(C_BIT_CLR,  PC_SQSTRT, 1'b0, 1'b0, A_ONE, B_BASE, D_NONE, 1'b0, 1'b0);
      4'd5:    w = uc_word(C_NONE,     4'd0,      1'b0, 1'b1, A_RES, B_SQ,   D_NONE, 1'b0, 1'b0);
      4'd6:    w = uc_word(C_MUL_BUSY, 4'd6,      1'b0, 1'b0, A_RES, B_SQ,   D_RES,  1'b0, 1'b0);
      4'd7:    w = uc_word(C_NONE,     4'd0,      1'b0, 1'b1, A_SQ,  B_SQ,   D_NONE, 1'b0, 1'b0);
      4'd8:    w = uc_word(C_MUL_BUSY, 4'd8,      1'b0, 1'b0, A_SQ,  B_SQ,   D_SQ,   1'b0, 1'b0);
      4'd9:    w = uc_word(C_NOT_LAST, PC_BITTST, 1'b0, 1'b0, A_ONE, B_BASE, D_NONE, 1'b1, 1'b0);
      4'd10:   w = uc_word(C_OUT_FULL, PC_EMIT,   1'b0, 1'b0, A_ONE, B_BASE, D_NONE, 1'b0, 1'b1);
      4'd11:   w = uc_word(C_ALWAYS,   PC_IDLE,   1'b0, 1'b0, A_ONE, B_BASE, D_NONE, 1'b0, 1'b0);
      default: w = uc_word(C_ALWAYS,   PC_IDLE,   1'b0, 1'b0, A_ONE, B_BASE, D_NONE, 1'b0, 1'b0);
    endcase
    return w;
  endfunction

endpackage

>>> rtl/modexp_mulmod.sv
// Bit-serial modular multiplier: p = a * b mod m by double-and-add, one bit of b per cycle.
// Needs a <= m, b any value, m >= 1. Standalone; no package use.
module modexp_mulmod #(
  parameter int WIDTH = 31
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  input  logic [WIDTH-1:0] m,
  output logic             done,
  output logic [WIDTH-1:0] p
);

  localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(WIDTH - 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [WIDTH-1:0] acc_r, acc_nxt;
  logic [WIDTH-1:0] b_r, b_nxt;

  logic [WIDTH:0] dbl, dbl_red, sum;
  logic [WIDTH:0] m_ext;

  // acc <- 2*acc mod m, then + a mod m when the bit is set; each sum stays below 2m
  always_comb begin
    m_ext   = {1'b0, m};
    dbl     = {acc_r, 1'b0};
    dbl_red = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
    sum     = dbl_red + (b_r[WIDTH-1] ? {1'b0, a} : '0);
    if (sum >= m_ext) begin
      sum = sum - m_ext;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    b_nxt    = b_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = LAST_CNT;
      acc_nxt  = '0;
      b_nxt    = b;
    end else if (busy_r) begin
      acc_nxt = sum[WIDTH-1:0];
      b_nxt   = {b_r[WIDTH-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    b_r   <= b_nxt;
  end

  assign done = done_r;
  assign p    = acc_r;

endmodule

>>> rtl/modexp_useq.sv
// Microcode sequencer: program counter, ROM lookup and branch evaluation.
// Depends on modexp_pkg for the control word, conditions and ROM.
module modexp_useq
  import modexp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  useq_stat_t stat,
  output ucode_t     uc
);

  logic [PC_W-1:0] pc_r, pc_nxt;
  logic            take;

  assign uc = ucode_rom(pc_r);

  always_comb begin
    case (uc.cond)
      C_NONE:     take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_NO_IN:    take = !stat.in_valid;
      C_SPECIAL:  take = stat.special;
      C_BIT_CLR:  take = !stat.exp_bit;
      C_NOT_LAST: take = !stat.last_bit;
      C_MUL_BUSY: take = !stat.mul_done;
      C_OUT_FULL: take = stat.out_block;
      default:    take = 1'b1;
    endcase
    pc_nxt = take ? uc.target : pc_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

>>> rtl/modular_exponentiation.sv
// Modular exponentiation, right-to-left square-and-multiply (textbook RSA core).
// Top level: config registers, operand registers, result register; uses modexp_pkg,
// modexp_useq and modexp_mulmod.
//
// For each accepted base the block returns base^exponent mod modulus, with exponent
// and modulus taken from two configuration registers (index 0 exponent, reset 1;
// index 1 modulus, reset all ones). All values are unsigned and WIDTH bits wide.
// Exponent zero gives 1 (even for modulus 1); modulus zero gives 0. The base is first
// reduced by the modulus, then every exponent bit from the LSB up costs one modular
// square and, where the bit is set, one modular multiply. Each modular multiply is done by a
// bit-serial double-and-add unit, and the microcode sequencer adds a bit test and an
// index step around it for each bit. All WIDTH bits are scanned regardless of the
// exponent's length. A special-case item (exponent or modulus zero) skips the
// multiplies and goes straight to the result register. One item is in work at a
// time; a new item is taken while the previous result still waits on the output.
// Configuration must only be written while the block is idle.
module modular_exponentiation
  import modexp_pkg::*;
#(
  parameter int WIDTH = 31
) (
  input  logic             clk,
  input  logic             rst_n,
  // configuration write port
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [WIDTH-1:0] cfg_data,
  // input transactions
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_base_value,
  // result transactions
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_power_result
);

  localparam int IDX_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WIDTH - 1);
  localparam logic [WIDTH-1:0] ONE      = WIDTH'(1);

  // configuration registers
  logic [WIDTH-1:0] exponent_r, exponent_nxt;
  logic [WIDTH-1:0] modulus_r, modulus_nxt;

  // datapath registers
  logic [WIDTH-1:0] base_r, base_nxt;
  logic [WIDTH-1:0] res_r, res_nxt;
  logic [WIDTH-1:0] sq_r, sq_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  // result register
  logic             out_valid_r, out_valid_nxt;
  logic [WIDTH-1:0] out_res_r, out_res_nxt;

  ucode_t           uc;
  useq_stat_t       stat;
  logic             mul_done;
  logic [WIDTH-1:0] mul_p;
  logic [WIDTH-1:0] op_a, op_b;
  logic             in_take;
  logic             out_block;
  logic             emit_en;
  logic             mod_zero, exp_zero;

  assign mod_zero  = (modulus_r == '0);
  assign exp_zero  = (exponent_r == '0);
  assign out_block = out_valid_r && !out_ready;
  assign in_take   = uc.load && in_valid;
  assign emit_en   = uc.emit && !out_block;

  assign stat.in_valid  = in_valid;
  assign stat.special   = mod_zero || exp_zero;
  assign stat.exp_bit   = exponent_r[idx_r];
  assign stat.last_bit  = (idx_r == LAST_IDX);
  assign stat.mul_done  = mul_done;
  assign stat.out_block = out_block;

  modexp_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .uc    (uc)
  );

  // operand select for the shared multiplier
  always_comb begin
    case (uc.a_sel)
      A_ONE:   op_a = ONE;
      A_RES:   op_a = res_r;
      A_SQ:    op_a = sq_r;
      default: op_a = ONE;
    endcase
    case (uc.b_sel)
      B_BASE:  op_b = base_r;
      B_SQ:    op_b = sq_r;
      default: op_b = base_r;
    endcase
  end

  modexp_mulmod #(
    .WIDTH (WIDTH)
  ) u_mulmod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (uc.start_mul),
    .a     (op_a),
    .b     (op_b),
    .m     (modulus_r),
    .done  (mul_done),
    .p     (mul_p)
  );

  always_comb begin
    exponent_nxt = exponent_r;
    modulus_nxt  = modulus_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_EXPONENT: exponent_nxt = cfg_data;
        CFG_MODULUS:  modulus_nxt  = cfg_data;
        default:      exponent_nxt = exponent_r;
      endcase
    end
  end

  always_comb begin
    base_nxt = base_r;
    res_nxt  = res_r;
    sq_nxt   = sq_r;
    idx_nxt  = idx_r;
    if (in_take) begin
      base_nxt = in_base_value;
      idx_nxt  = '0;
      // modulus zero -> 0; exponent zero -> 1; else start from 1 mod m
      if (mod_zero) begin
        res_nxt = '0;
      end else if (exp_zero) begin
        res_nxt = ONE;
      end else if (modulus_r == ONE) begin
        res_nxt = '0;
      end else begin
        res_nxt = ONE;
      end
    end
    if (mul_done) begin
      case (uc.dst)
        D_SQ:    sq_nxt  = mul_p;
        D_RES:   res_nxt = mul_p;
        default: sq_nxt  = sq_r;
      endcase
    end
    if (uc.idx_inc) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit_en) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exponent_r  <= ONE;
      modulus_r   <= '1;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      exponent_r  <= exponent_nxt;
      modulus_r   <= modulus_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
    base_r    <= base_nxt;
    res_r     <= res_nxt;
    sq_r      <= sq_nxt;
    out_res_r <= out_res_nxt;
  end

  assign in_ready         = uc.load;
  assign out_valid        = out_valid_r;
  assign out_power_result = out_res_r;

endmodule
